### rtl/gpio_register_block_macros.svh
// Assertion helpers for the GPIO register block.
`ifndef GPIO_REGISTER_BLOCK_MACROS_SVH
`define GPIO_REGISTER_BLOCK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRB_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define GRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gpio_rb_pkg.sv
`default_nettype none
package gpio_rb_pkg;

   // Pins actually present (1 to 64)
   localparam int PIN_COUNT = 58;
   // Fixed field widths
   localparam int PIN_W    = 58;
   localparam int DATA_W   = 32;
   localparam int WORD_W   = 6;
   localparam int VEC_W    = 64;

   // Function select words: 10 pins of 3 bits each
   localparam int FSEL_WORDS     = 6;
   localparam int PINS_PER_FSEL  = 10;
   localparam int FSEL_FIELD_W   = 3;
   localparam int FSEL_W         = PINS_PER_FSEL * FSEL_FIELD_W;
   // Pull words: 16 pins of 2 bits each
   localparam int PULL_WORDS     = 4;
   localparam int PINS_PER_PULL  = 16;
   localparam int PULL_FIELD_W   = 2;
   localparam int PULL_W         = PINS_PER_PULL * PULL_FIELD_W;

   localparam logic [FSEL_FIELD_W-1:0] FSEL_OUTPUT = 3'd1;

   localparam logic [VEC_W-1:0] PIN_MASK =
      (PIN_COUNT >= VEC_W) ? {VEC_W{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

   // Register word map
   localparam logic [WORD_W-1:0] WORD_FSEL0 = 6'd0;
   localparam logic [WORD_W-1:0] WORD_SET0  = 6'd7;
   localparam logic [WORD_W-1:0] WORD_SET1  = 6'd8;
   localparam logic [WORD_W-1:0] WORD_CLR0  = 6'd10;
   localparam logic [WORD_W-1:0] WORD_CLR1  = 6'd11;
   localparam logic [WORD_W-1:0] WORD_LEV0  = 6'd13;
   localparam logic [WORD_W-1:0] WORD_LEV1  = 6'd14;
   localparam logic [WORD_W-1:0] WORD_PULL0 = 6'd57;

   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] word_offset;
      logic [DATA_W-1:0] write_data;
      logic [PIN_W-1:0]  pad_levels;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [PIN_W-1:0]  drive_levels;
      logic [PIN_W-1:0]  drive_enables;
   } rsp_type;

   // Writable bits of function select word w (absent pins stay zero)
   function automatic logic [FSEL_W-1:0] fsel_mask(input int w);
      logic [FSEL_W-1:0] m;
      m = '0;
      for (int k = 0; k < PINS_PER_FSEL; k++) begin
         if (w * PINS_PER_FSEL + k < PIN_COUNT) begin
            m[FSEL_FIELD_W*k +: FSEL_FIELD_W] = {FSEL_FIELD_W{1'b1}};
         end
      end
      return m;
   endfunction

   // Writable bits of pull word w
   function automatic logic [PULL_W-1:0] pull_mask(input int w);
      logic [PULL_W-1:0] m;
      m = '0;
      for (int k = 0; k < PINS_PER_PULL; k++) begin
         if (w * PINS_PER_PULL + k < PIN_COUNT) begin
            m[PULL_FIELD_W*k +: PULL_FIELD_W] = {PULL_FIELD_W{1'b1}};
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/gpio_rb_regs.sv
`default_nettype none
module gpio_rb_regs
   import gpio_rb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    commit,
   input  wire req_type req,
   output rsp_type      rsp
);

   logic [FSEL_W-1:0] fsel_ff [FSEL_WORDS];
   logic [FSEL_W-1:0] fsel_in [FSEL_WORDS];
   logic [PULL_W-1:0] pull_ff [PULL_WORDS];
   logic [PULL_W-1:0] pull_in [PULL_WORDS];
   logic [VEC_W-1:0]  latch_ff;
   logic [VEC_W-1:0]  latch_in;
   logic [VEC_W-1:0]  pads;
   logic [VEC_W-1:0]  data_lo;
   logic [VEC_W-1:0]  data_hi;
   logic [PIN_W-1:0]  enables;
   logic              is_write;
   logic [DATA_W-1:0] rd;

   assign is_write = (req.action == ACT_WRITE);
   assign pads     = {{(VEC_W-PIN_W){1'b0}}, req.pad_levels} & PIN_MASK;
   assign data_lo  = {{(VEC_W-DATA_W){1'b0}}, req.write_data} & PIN_MASK;
   assign data_hi  = {req.write_data, {(VEC_W-DATA_W){1'b0}}} & PIN_MASK;

   // Next state of the select words and the output latch
   always_comb begin
      for (int w = 0; w < FSEL_WORDS; w++) begin
         fsel_in[w] = fsel_ff[w];
         if (is_write && req.word_offset == WORD_FSEL0 + WORD_W'(w)) begin
            fsel_in[w] = req.write_data[FSEL_W-1:0] & fsel_mask(w);
         end
      end
      for (int w = 0; w < PULL_WORDS; w++) begin
         pull_in[w] = pull_ff[w];
         if (is_write && req.word_offset == WORD_PULL0 + WORD_W'(w)) begin
            pull_in[w] = req.write_data & pull_mask(w);
         end
      end
      latch_in = latch_ff;
      if (is_write) begin
         case (req.word_offset)
            WORD_SET0: latch_in = latch_ff | data_lo;
            WORD_SET1: latch_in = latch_ff | data_hi;
            WORD_CLR0: latch_in = latch_ff & ~data_lo;
            WORD_CLR1: latch_in = latch_ff & ~data_hi;
            default:   latch_in = latch_ff;
         endcase
      end
   end

   // Read mux; writes and unmapped words return zero
   always_comb begin
      rd = '0;
      if (!is_write) begin
         for (int w = 0; w < FSEL_WORDS; w++) begin
            if (req.word_offset == WORD_FSEL0 + WORD_W'(w)) begin
               rd = {{(DATA_W-FSEL_W){1'b0}}, fsel_ff[w]};
            end
         end
         for (int w = 0; w < PULL_WORDS; w++) begin
            if (req.word_offset == WORD_PULL0 + WORD_W'(w)) begin
               rd = pull_ff[w];
            end
         end
         if (req.word_offset == WORD_LEV0) begin
            rd = pads[DATA_W-1:0];
         end
         if (req.word_offset == WORD_LEV1) begin
            rd = pads[VEC_W-1:DATA_W];
         end
      end
   end

   // Output enable per pin from the updated function select
   for (genvar p = 0; p < PIN_W; p++) begin : g_en
      if (p < FSEL_WORDS * PINS_PER_FSEL) begin : g_mapped
         assign enables[p] = (fsel_in[p / PINS_PER_FSEL]
            [FSEL_FIELD_W*(p % PINS_PER_FSEL) +: FSEL_FIELD_W] == FSEL_OUTPUT);
      end else begin : g_unmapped
         assign enables[p] = 1'b0;
      end
   end

   assign rsp.read_data     = rd;
   assign rsp.drive_levels  = latch_in[PIN_W-1:0];
   assign rsp.drive_enables = enables;

   // State registers, updated when the request commits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < FSEL_WORDS; w++) fsel_ff[w] <= '0;
         for (int w = 0; w < PULL_WORDS; w++) pull_ff[w] <= '0;
         latch_ff <= '0;
      end else if (commit) begin
         fsel_ff  <= fsel_in;
         pull_ff  <= pull_in;
         latch_ff <= latch_in;
      end
   end

endmodule
`default_nettype wire

### rtl/gpio_register_block.sv
// GPIO register block, bus side.
// Request channel (req_*): one 32-bit word access per request: action
// (0 read, 1 write), word offset, write data and the sampled pad levels.
// Response channel (rsp_*): one response per request, in order: read data
// (zero on writes), output latch and output enables of every pin after
// the access.
// A request accepted into the input register is decoded and applied when
// it commits, which loads its response into the response register and
// sets rsp_valid.
// Throughput: one request per cycle unless stalled, set by the input
// register feeding one decode and update pass into the response register.
// Reset (synchronous, active high) clears all function selects, pulls and
// output latches and empties both stages.
// When the receiver stalls the response is held unchanged; one more
// request is taken into the input register, after which req_stall rises
// until the response is taken.
`default_nettype none
`include "gpio_register_block_macros.svh"
module gpio_register_block
   import gpio_rb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic              req_action,
   input  wire logic [WORD_W-1:0] req_word_offset,
   input  wire logic [DATA_W-1:0] req_write_data,
   input  wire logic [PIN_W-1:0]  req_pad_levels,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [DATA_W-1:0] rsp_read_data,
   output      logic [PIN_W-1:0]  rsp_drive_levels,
   output      logic [PIN_W-1:0]  rsp_drive_enables
);

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    advance;
   logic    commit;
   logic    accept;

   // Pipeline control
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign commit       = s1_valid_ff && advance;
   assign req_stall    = s1_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !commit);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.action      <= req_action;
         s1_req_ff.word_offset <= req_word_offset;
         s1_req_ff.write_data  <= req_write_data;
         s1_req_ff.pad_levels  <= req_pad_levels;
      end
   end

   // Decode and register state
   gpio_rb_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .req    (s1_req_ff),
      .rsp    (rsp_next)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_drive_levels  = rsp_ff.drive_levels;
   assign rsp_drive_enables = rsp_ff.drive_enables;

   // Checks
   `GRB_ASSERT_NEXT(a_commit_loads, commit, rsp_valid_ff,
      "committed request gave no response")
   `GRB_ASSERT_NEXT(a_write_reads_zero, commit && s1_req_ff.action == ACT_WRITE,
      rsp_ff.read_data == '0, "write returned nonzero read data")
   `GRB_ASSERT_IMPLY(a_absent_pins, rsp_valid_ff,
      (rsp_ff.drive_levels & ~PIN_MASK[PIN_W-1:0]) == '0, "absent pin latched")

endmodule
`default_nettype wire
